### hw/rtl/sfit_pkg.sv
// sfit_pkg: shared widths, register indexes and the config register type
// for the start/finish interval timer. No dependencies.
`timescale 1ns / 1ps

package sfit_pkg;

    localparam int LABEL_W   = 4;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 41;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_START_LABEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_LABEL = 2'd1;

    localparam logic [LABEL_W-1:0] START_LABEL_RST  = 4'd1;
    localparam logic [LABEL_W-1:0] FINISH_LABEL_RST = 4'd2;

    typedef struct packed {
        logic [LABEL_W-1:0] start_label;
        logic [LABEL_W-1:0] finish_label;
    } t_cfg;

endpackage

### hw/rtl/sfit_if.sv
// sfit_if: valid/ready channel interfaces for windows, results and config.
// Depends on sfit_pkg.
`timescale 1ns / 1ps

interface sfit_win_if;
    logic                          valid;
    logic                          ready;
    logic [sfit_pkg::LABEL_W-1:0]  class_label;
    logic [sfit_pkg::TIME_W-1:0]   window_time;
    logic                          last_window;

    modport source (output valid, class_label, window_time, last_window, input ready);
    modport sink   (input valid, class_label, window_time, last_window, output ready);
endinterface

interface sfit_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [sfit_pkg::DUR_W-1:0] duration;
    logic                             status;

    modport source (output valid, duration, status, input ready);
    modport sink   (input valid, duration, status, output ready);
endinterface

interface sfit_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfit_pkg::CFG_IDX_W-1:0] index;
    logic [sfit_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/sfit_div.sv
// sfit_div: restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the start/finish interval timer for both run means.
`timescale 1ns / 1ps

module sfit_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_acc;   // numerator shifts out, quotient shifts in
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_acc[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= {r_acc[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

### hw/rtl/start_finish_interval_timer.sv
// start_finish_interval_timer: tracks start/finish label runs over a window
// stream and reports mean finish time minus mean start time.
// Depends on sfit_pkg, sfit_if (channels) and sfit_div (shared divider).
`timescale 1ns / 1ps

// Usage
//   i_win : one beat per classified window (class_label, window_time,
//           last_window). A beat without last_window is folded into the run
//           counters as it is taken, so such beats stream at one per cycle.
//   o_res : one beat per sequence, produced after the last_window beat:
//           duration (signed, FRAC_BITS fraction bits) and status
//           (0 ok, 1 no start/finish pair; duration then holds -1.0).
//   i_cfg : register writes (index 0 start label, 1 finish label), always
//           ready; write only while the block is idle.
//   Result sequence: after a last_window beat the shared divider runs twice,
//   one quotient bit per cycle, NW = min(TIME_BITS,32) + clog2(MAX_WINDOWS+1)
//   + FRAC_BITS bits each. i_win is not ready until the result has been
//   handed to the output register. With no pair completed the divider is
//   skipped and the result goes straight to the output state.
//   Stall: a result waits in the output register; a second result waits in
//   the holding state until o_res is free, and i_win stays low meanwhile.
//   Reset: synchronous, active low; clears all run state and restores the
//   default labels (start 1, finish 2).
module start_finish_interval_timer #(
    parameter int MAX_WINDOWS = 1024,
    parameter int TIME_BITS   = 32,
    parameter int FRAC_BITS   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sfit_win_if.sink         i_win,
    sfit_res_if.source       o_res,
    sfit_cfg_if.sink         i_cfg
);

    localparam int TB = (TIME_BITS < sfit_pkg::TIME_W) ? TIME_BITS : sfit_pkg::TIME_W;
    localparam int CW = $clog2(MAX_WINDOWS + 1);     // run count
    localparam int SW = TB + CW;                     // run sum
    localparam int NW = SW + FRAC_BITS;              // divider numerator
    localparam int QW = (NW > sfit_pkg::DUR_W) ? NW : sfit_pkg::DUR_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOADF = 3'd1;   // start finish-run mean
    localparam logic [2:0] ST_WAITF = 3'd2;
    localparam logic [2:0] ST_LOADS = 3'd3;   // start start-run mean
    localparam logic [2:0] ST_WAITS = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;   // hand result to output reg

    // finish phase codes
    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [2:0]            r_state;
    sfit_pkg::t_cfg        r_cfg;

    // run tracking
    logic [CW-1:0]         r_start_cnt, n_start_cnt;
    logic [SW-1:0]         r_start_sum, n_start_sum;
    logic                  r_prev_start, n_prev_start;
    logic                  r_start_seen, n_start_seen;
    logic [1:0]            r_phase, n_phase;
    logic [CW-1:0]         r_fin_cnt, n_fin_cnt;
    logic [SW-1:0]         r_fin_sum, n_fin_sum;

    // result path
    logic [NW-1:0]                     r_mean_fin;
    logic signed [sfit_pkg::DUR_W-1:0] r_res_dur;
    logic                              r_res_stat;
    logic                              r_out_valid;
    logic signed [sfit_pkg::DUR_W-1:0] r_out_dur;
    logic                              r_out_stat;

    logic                  w_win_acc;
    logic [SW-1:0]         w_t;
    logic [SW-1:0]         w_sel_sum;
    logic [CW-1:0]         w_sel_cnt;
    logic [NW-1:0]         w_num;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [NW-1:0]         w_quot;
    logic [QW-1:0]         w_diff;
    logic                  w_out_free;

    assign i_win.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_win_acc   = i_win.valid && i_win.ready;
    assign w_t         = SW'(i_win.window_time[TB-1:0]);
    assign w_out_free  = !r_out_valid || o_res.ready;

    // run update for one window
    always_comb begin
        n_start_cnt  = r_start_cnt;
        n_start_sum  = r_start_sum;
        n_prev_start = r_prev_start;
        n_start_seen = r_start_seen;
        n_phase      = r_phase;
        n_fin_cnt    = r_fin_cnt;
        n_fin_sum    = r_fin_sum;
        case (r_phase)
            PH_SEEK: begin
                if (i_win.class_label == r_cfg.start_label) begin
                    if (!r_prev_start) begin
                        n_start_cnt = CW'(1);
                        n_start_sum = w_t;
                    end else if (r_start_cnt < CW'(MAX_WINDOWS)) begin
                        n_start_cnt = r_start_cnt + CW'(1);
                        n_start_sum = r_start_sum + w_t;
                    end
                    n_prev_start = 1'b1;
                    n_start_seen = 1'b1;
                end else if (i_win.class_label == r_cfg.finish_label && r_start_seen) begin
                    n_phase      = PH_RUN;
                    n_fin_cnt    = CW'(1);
                    n_fin_sum    = w_t;
                    n_prev_start = 1'b0;
                end else begin
                    n_prev_start = 1'b0;
                end
            end
            PH_RUN: begin
                if (i_win.class_label == r_cfg.finish_label) begin
                    if (r_fin_cnt < CW'(MAX_WINDOWS)) begin
                        n_fin_cnt = r_fin_cnt + CW'(1);
                        n_fin_sum = r_fin_sum + w_t;
                    end
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // rounded mean numerator: sum * 2^F + count/2
    assign w_sel_sum   = (r_state == ST_LOADS) ? r_start_sum : r_fin_sum;
    assign w_sel_cnt   = (r_state == ST_LOADS) ? r_start_cnt : r_fin_cnt;
    assign w_num       = (NW'(w_sel_sum) << FRAC_BITS) + NW'(w_sel_cnt >> 1);
    assign w_div_start = (r_state == ST_LOADF) || (r_state == ST_LOADS);
    assign w_diff      = QW'(r_mean_fin) - QW'(w_quot);

    sfit_div #(
        .NUM_W (NW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_sel_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg        <= '{start_label: sfit_pkg::START_LABEL_RST,
                              finish_label: sfit_pkg::FINISH_LABEL_RST};
            r_start_cnt  <= '0;
            r_start_sum  <= '0;
            r_prev_start <= 1'b0;
            r_start_seen <= 1'b0;
            r_phase      <= PH_SEEK;
            r_fin_cnt    <= '0;
            r_fin_sum    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    sfit_pkg::CFG_START_LABEL:  r_cfg.start_label  <= i_cfg.data;
                    sfit_pkg::CFG_FINISH_LABEL: r_cfg.finish_label <= i_cfg.data;
                    default: ;
                endcase
            end

            // in ST_OUT the hand-off below decides the output valid
            if (r_out_valid && o_res.ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_win_acc) begin
                        r_start_cnt  <= n_start_cnt;
                        r_start_sum  <= n_start_sum;
                        r_prev_start <= n_prev_start;
                        r_start_seen <= n_start_seen;
                        r_phase      <= n_phase;
                        r_fin_cnt    <= n_fin_cnt;
                        r_fin_sum    <= n_fin_sum;
                        if (i_win.last_window) begin
                            r_state <= (n_phase != PH_SEEK) ? ST_LOADF : ST_OUT;
                        end
                    end
                end
                ST_LOADF: r_state <= ST_WAITF;
                ST_WAITF: begin
                    if (w_div_done) begin
                        r_state <= ST_LOADS;
                    end
                end
                ST_LOADS: r_state <= ST_WAITS;
                ST_WAITS: begin
                    if (w_div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_start_cnt  <= '0;
                        r_start_sum  <= '0;
                        r_prev_start <= 1'b0;
                        r_start_seen <= 1'b0;
                        r_phase      <= PH_SEEK;
                        r_fin_cnt    <= '0;
                        r_fin_sum    <= '0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WAITF && w_div_done) begin
            r_mean_fin <= w_quot;
        end
        if (r_state == ST_IDLE && w_win_acc && i_win.last_window) begin
            // no pair: -1.0 in the fixed-point format
            r_res_dur  <= -(sfit_pkg::DUR_W'(1) << FRAC_BITS);
            r_res_stat <= 1'b1;
        end else if (r_state == ST_WAITS && w_div_done) begin
            r_res_dur  <= w_diff[sfit_pkg::DUR_W-1:0];
            r_res_stat <= 1'b0;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out_dur  <= r_res_dur;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.duration = r_out_dur;
    assign o_res.status   = r_out_stat;

`ifndef ASSERT_OFF
    a_fin_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_SEEK) |-> (r_start_seen && r_fin_cnt != '0))
        else $error("finish phase open with empty run or no start");

    a_start_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start_seen |-> (r_start_cnt != '0))
        else $error("start seen but start run empty");

    a_last_starts_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_win_acc && i_win.last_window) |=> (r_state == ST_LOADF || r_state == ST_OUT))
        else $error("last window did not start result sequence");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_WAITF || r_state == ST_WAITS))
        else $error("divider finished outside a wait state");
`endif

endmodule
